[rtl/core/lts_pkg.sv]
// shared types, constants and codes of the lottery ticket scheduler
`timescale 1ns / 1ps

package lts_pkg;

   // default sizing
   localparam int SLOTS_DEF       = 16;
   localparam int TICKET_BITS_DEF = 16;

   // fixed field widths of the request and response
   localparam int SLOT_W     = 4;
   localparam int REQ_TKT_W  = 16;
   localparam int RANDOM_W   = 32;
   localparam int MOVED_W    = 16;
   localparam int OUT_TOT_W  = 20;
   localparam longint unsigned OUT_TOT_MAX = (64'd1 << OUT_TOT_W) - 64'd1;

   // command codes
   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_XFER = 2'd1,
      CMD_DRAW = 2'd2
   } cmd_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_XSRC,
      ST_XDST,
      ST_XCALC,
      ST_XWR,
      ST_SUM,
      ST_SUMEND,
      ST_DIVGO,
      ST_DIVWAIT,
      ST_SCAN,
      ST_SCANEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type               command;
      logic [SLOT_W-1:0]     slot;
      logic [SLOT_W-1:0]     other_slot;
      logic [REQ_TKT_W-1:0]  tickets;
      logic                  present;
      logic                  runnable;
      logic [RANDOM_W-1:0]   random_value;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]     chosen_slot;
      logic                  chosen_found;
      logic [MOVED_W-1:0]    moved_tickets;
      logic [OUT_TOT_W-1:0]  total_tickets;
   } rsp_type;

endpackage

[rtl/core/lts_table.sv]
// slot table memory: ticket count and flags per slot, one read and one write port
`timescale 1ns / 1ps

module lts_table #(
   parameter int SLOTS       = 16,
   parameter int TICKET_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic [TICKET_BITS-1:0]   rd_count,
   output logic                     rd_present,
   output logic                     rd_runnable,
   input  logic                     wr_en,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  logic [TICKET_BITS-1:0]   wr_count,
   input  logic                     wr_present,
   input  logic                     wr_runnable
);
   localparam int ENTRY_W = TICKET_BITS + 2;

   logic [ENTRY_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0]   valid_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_valid_ff;

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_present, wr_runnable, wr_count};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // per-entry written marks, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // unwritten entries read as zero
   assign rd_count    = rd_valid_ff ? rd_data_ff[TICKET_BITS-1:0] : '0;
   assign rd_runnable = rd_valid_ff & rd_data_ff[TICKET_BITS];
   assign rd_present  = rd_valid_ff & rd_data_ff[TICKET_BITS+1];

endmodule

[rtl/core/lts_mod_unit.sv]
// serial restoring modulo unit, one dividend bit per cycle
`timescale 1ns / 1ps

module lts_mod_unit #(
   parameter int DIVIDEND_W = 32,
   parameter int DIVISOR_W  = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVISOR_W-1:0]  remainder
);
   localparam int STEP_W = $clog2(DIVIDEND_W);

   logic                  run_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    rem_in;

   // shift in the next dividend bit and subtract when it fits
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = trial - {1'b0, div_ff};
      end else begin
         rem_in = trial;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], 1'b0};
         rem_ff <= rem_in[DIVISOR_W-1:0];
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[rtl/core/lottery_ticket_scheduler.sv]
// top level: request sequencer of the lottery ticket scheduler
`timescale 1ns / 1ps

// Lottery ticket scheduler. A request is taken at a rising edge with start high
// and busy low; busy then stays high until the response strobe is done.
// Every request gives exactly one response, shown for one cycle with
// rsp_valid high; the receiver cannot hold it off.
// Load writes one slot of the table; transfer moves tickets between two slots
// and reports the amount moved; draw sums the eligible slots, reduces the
// random value modulo that sum and scans for the winning slot.
// All slot state sits in one table memory with a registered read; every step
// reads or writes it one entry a cycle.
// A draw sums every slot, then runs the serial modulo (skipped when the sum is
// zero), then scans up to the first slot that reaches the winning ticket; the
// modulo unit takes one random bit a cycle.
// busy drops the cycle after the strobe, so the next request is taken then.
// Reset clears the sequencer and marks every slot as zero tickets, absent and
// not runnable; no clearing pass is needed.

module lottery_ticket_scheduler #(
   parameter int SLOTS       = lts_pkg::SLOTS_DEF,
   parameter int TICKET_BITS = lts_pkg::TICKET_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  lts_pkg::req_type req_data,
   output logic            rsp_valid,
   output lts_pkg::rsp_type rsp_data
);
   import lts_pkg::*;

   localparam int IDX_W   = $clog2(SLOTS);
   localparam int TOTAL_W = TICKET_BITS + IDX_W;

   state_type state_ff, state_in;

   req_type               req_ff;
   logic [IDX_W-1:0]      cnt_ff;
   logic [IDX_W-1:0]      data_idx_ff;
   logic                  rd_vld_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic [TOTAL_W-1:0]    run_ff;
   logic [TOTAL_W-1:0]    pick_ff;
   logic                  found_ff;
   logic [IDX_W-1:0]      chosen_ff;
   logic [TICKET_BITS-1:0] moved_ff;
   logic [TICKET_BITS-1:0] src_cnt_ff;
   logic                  src_pres_ff;
   logic                  src_run_ff;
   logic                  dst_pres_ff;
   logic                  dst_run_ff;
   logic [TICKET_BITS-1:0] dst_new_ff;
   logic                  xfer_ok_ff;

   logic                  accept;
   logic                  src_in_range;
   logic                  dst_in_range;
   logic [IDX_W-1:0]      src_addr;
   logic [IDX_W-1:0]      dst_addr;

   logic [IDX_W-1:0]       rd_addr;
   logic [TICKET_BITS-1:0] rd_count;
   logic                   rd_present;
   logic                   rd_runnable;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [TICKET_BITS-1:0] wr_count;
   logic                   wr_present;
   logic                   wr_runnable;

   logic                   div_start;
   logic                   div_done;
   logic [TOTAL_W-1:0]     div_rem;

   logic                   eligible;
   logic [TOTAL_W-1:0]     run_next;
   logic                   scan_hit;
   logic                   last_idx;

   logic                   xfer_ok;
   logic [TICKET_BITS-1:0] offer_req;
   logic [TICKET_BITS-1:0] room;
   logic [TICKET_BITS-1:0] offer;

   assign accept       = start & ~busy;
   assign src_in_range = 32'(req_ff.slot) < SLOTS;
   assign dst_in_range = 32'(req_ff.other_slot) < SLOTS;
   assign src_addr     = IDX_W'(req_ff.slot);
   assign dst_addr     = IDX_W'(req_ff.other_slot);
   assign last_idx     = cnt_ff == IDX_W'(SLOTS - 1);

   // slot table
   lts_table #(
      .SLOTS       (SLOTS),
      .TICKET_BITS (TICKET_BITS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .rd_addr     (rd_addr),
      .rd_count    (rd_count),
      .rd_present  (rd_present),
      .rd_runnable (rd_runnable),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_count    (wr_count),
      .wr_present  (wr_present),
      .wr_runnable (wr_runnable)
   );

   // random value modulo ticket total
   lts_mod_unit #(
      .DIVIDEND_W (RANDOM_W),
      .DIVISOR_W  (TOTAL_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_ff.random_value),
      .divisor   (total_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // draw scan: running sum and hit test on the entry just read
   assign eligible = rd_vld_ff & rd_present & rd_runnable;
   assign run_next = run_ff + TOTAL_W'(rd_count);
   assign scan_hit = eligible & (run_next >= pick_ff);

   // transfer amount, source entry latched and destination on the read port
   always_comb begin
      xfer_ok = src_in_range & dst_in_range & (src_addr != dst_addr)
                & src_pres_ff & rd_present & (src_cnt_ff != '0);
      if (33'(req_ff.tickets) >= 33'(src_cnt_ff)) begin
         offer_req = src_cnt_ff - 1'b1;
      end else begin
         offer_req = TICKET_BITS'(req_ff.tickets);
      end
      room = ~rd_count;
      if (offer_req > room) begin
         offer = room;
      end else begin
         offer = offer_req;
      end
      if (!xfer_ok) begin
         offer = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  CMD_LOAD: state_in = ST_LOAD;
                  CMD_XFER: state_in = ST_XSRC;
                  CMD_DRAW: state_in = ST_SUM;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_LOAD:    state_in = ST_DONE;
         ST_XSRC:    state_in = ST_XDST;
         ST_XDST:    state_in = ST_XCALC;
         ST_XCALC:   state_in = ST_XWR;
         ST_XWR:     state_in = ST_DONE;
         ST_SUM:     state_in = last_idx ? ST_SUMEND : ST_SUM;
         ST_SUMEND:  state_in = ST_DIVGO;
         ST_DIVGO:   state_in = (total_ff == '0) ? ST_SCAN : ST_DIVWAIT;
         ST_DIVWAIT: state_in = div_done ? ST_SCAN : ST_DIVWAIT;
         ST_SCAN: begin
            priority if (scan_hit) begin
               state_in = ST_DONE;
            end else if (last_idx) begin
               state_in = ST_SCANEND;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCANEND: state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control outputs and table port
   always_comb begin
      busy        = state_ff != ST_IDLE;
      rsp_valid   = state_ff == ST_DONE;
      div_start   = (state_ff == ST_DIVGO) && (total_ff != '0);
      rd_addr     = cnt_ff;
      wr_en       = 1'b0;
      wr_addr     = src_addr;
      wr_count    = TICKET_BITS'(req_ff.tickets);
      wr_present  = req_ff.present;
      wr_runnable = req_ff.runnable;
      unique case (state_ff)
         ST_LOAD: begin
            wr_en = src_in_range;
         end
         ST_XSRC: begin
            rd_addr = src_addr;
         end
         ST_XDST: begin
            rd_addr = dst_addr;
         end
         ST_XCALC: begin
            wr_en       = xfer_ok;
            wr_count    = src_cnt_ff - offer;
            wr_present  = src_pres_ff;
            wr_runnable = src_run_ff;
         end
         ST_XWR: begin
            wr_en       = xfer_ok_ff;
            wr_addr     = dst_addr;
            wr_count    = dst_new_ff;
            wr_present  = dst_pres_ff;
            wr_runnable = dst_run_ff;
         end
         default: begin
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == ST_SUM) || (state_ff == ST_SCAN);
         if ((state_ff == ST_SUM) || (state_ff == ST_SCAN)) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else begin
            cnt_ff <= '0;
         end
      end
   end

   // request, working and result registers
   always_ff @(posedge clock) begin
      data_idx_ff <= cnt_ff;
      if (accept) begin
         req_ff    <= req_data;
         total_ff  <= '0;
         run_ff    <= '0;
         found_ff  <= 1'b0;
         chosen_ff <= '0;
         moved_ff  <= '0;
      end
      // transfer: hold source entry, then compute the move
      if (state_ff == ST_XDST) begin
         src_cnt_ff  <= rd_count;
         src_pres_ff <= rd_present;
         src_run_ff  <= rd_runnable;
      end
      if (state_ff == ST_XCALC) begin
         moved_ff    <= offer;
         dst_new_ff  <= rd_count + offer;
         dst_pres_ff <= rd_present;
         dst_run_ff  <= rd_runnable;
         xfer_ok_ff  <= xfer_ok;
      end
      // draw: total over eligible slots
      if (((state_ff == ST_SUM) || (state_ff == ST_SUMEND)) && eligible) begin
         total_ff <= total_ff + TOTAL_W'(rd_count);
      end
      // draw: winning ticket
      if ((state_ff == ST_DIVGO) && (total_ff == '0)) begin
         pick_ff <= '0;
      end
      if ((state_ff == ST_DIVWAIT) && div_done) begin
         pick_ff <= div_rem + 1'b1;
      end
      // draw: scan for the first slot reaching the ticket
      if ((state_ff == ST_SCAN) || (state_ff == ST_SCANEND)) begin
         if (eligible) begin
            run_ff <= run_next;
         end
         if (scan_hit) begin
            found_ff  <= 1'b1;
            chosen_ff <= data_idx_ff;
         end
      end
   end

   // response fields
   always_comb begin
      rsp_data.chosen_slot   = SLOT_W'(chosen_ff);
      rsp_data.chosen_found  = found_ff;
      rsp_data.moved_tickets = MOVED_W'(moved_ff);
      if (64'(total_ff) > OUT_TOT_MAX) begin
         rsp_data.total_tickets = OUT_TOT_W'(OUT_TOT_MAX);
      end else begin
         rsp_data.total_tickets = OUT_TOT_W'(total_ff);
      end
   end

   // checks
   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.moved_tickets != '0)) |->
      (!rsp_data.chosen_found && (rsp_data.total_tickets == '0)))
      else $error("transfer response carries draw fields");

endmodule
